[design/ssfb_pkg.sv]
// ----------------------------------------------------------------------------
// ssfb_pkg
// Shared widths, codes, control struct and helper functions for the stereo
// spaced-tap FIR boost filter.
// ----------------------------------------------------------------------------
package ssfb_pkg;

    localparam int MAX_TAPS      = 64;
    localparam int HISTORY_DEPTH = 256;
    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 18;
    localparam int MAX_SPACING   = 4;

    localparam int TAP_AW  = $clog2(MAX_TAPS);
    localparam int TAP_CW  = $clog2(MAX_TAPS + 1);
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int BASE_W  = $clog2(MAX_TAPS * MAX_SPACING + 1);

    // configuration register widths
    localparam int WG_BITS       = 17;
    localparam int TAPC_BITS     = 7;
    localparam int SPC_BITS      = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_WET_GAIN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPACING   = 2'd2;

    // Q1.16 gains
    localparam logic [WG_BITS-1:0] GAIN_ONE  = 17'd65536;
    localparam logic [WG_BITS-1:0] GAIN_HALF = 17'd32768;
    localparam logic [WG_BITS-1:0] DRY_BASE  = 17'd98304;

    // accumulator holds up to MAX_TAPS*MAX_SPACING products
    localparam int ACC_W   = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS * MAX_SPACING) + 1;
    localparam int FILT_W  = ACC_W - 16;
    localparam int MUL_A_W = FILT_W;
    localparam int MUL_B_W = (COEF_BITS > WG_BITS + 1) ? COEF_BITS : WG_BITS + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // multiplier operand selects
    localparam logic [1:0] SEL_TAP  = 2'd0;
    localparam logic [1:0] SEL_MEAN = 2'd1;
    localparam logic [1:0] SEL_WET  = 2'd2;
    localparam logic [1:0] SEL_DRY  = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic [WG_BITS-1:0]            gain_t;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] sel;
        logic       acc_clr;
    } ssfb_ctrl_t;

    // neighbour-mean weight, Q1.16
    function automatic gain_t mean_weight(input logic [SPC_BITS-1:0] sp);
        gain_t w;
        case (sp)
            3'd2:    w = 17'd32768;
            3'd3:    w = 17'd21823;
            3'd4:    w = 17'd16384;
            default: w = 17'd65536;
        endcase
        return w;
    endfunction

    function automatic sample_t sat_sample(input logic signed [FILT_W:0] v);
        logic signed [FILT_W:0] hi;
        logic signed [FILT_W:0] lo;
        sample_t                r;
        hi = (FILT_W + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - (FILT_W + 1)'(1);
        if (v > hi) begin
            r = hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            r = lo[SAMPLE_BITS-1:0];
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[design/ssfb_chan.sv]
// ----------------------------------------------------------------------------
// ssfb_chan
// One channel datapath: a single registered multiplier shared by the tap
// MACs and the mean, wet and dry scaling steps, plus accumulator and
// saturating output sum.
// ----------------------------------------------------------------------------
module ssfb_chan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssfb_pkg::ssfb_ctrl_t ctrl,
    input  ssfb_pkg::sample_t    tap_sample,
    input  ssfb_pkg::coef_t      tap_coef,
    input  ssfb_pkg::sample_t    dry_sample,
    input  ssfb_pkg::gain_t      mean_wt,
    input  ssfb_pkg::gain_t      wet_gain,
    input  ssfb_pkg::gain_t      dry_gain,
    output ssfb_pkg::sample_t    result
);
    import ssfb_pkg::*;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [1:0]                sel_reg;
    logic                      pv_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [FILT_W-1:0]  filt;
    logic signed [FILT_W-1:0]  mean_reg;
    logic signed [FILT_W-1:0]  wet_reg;
    logic signed [FILT_W-1:0]  dry_reg;
    logic signed [FILT_W:0]    sum;

    assign filt = $signed(acc_reg[ACC_W-1:16]);

    always_comb begin
        case (ctrl.sel)
            SEL_TAP: begin
                op_a = MUL_A_W'(tap_sample);
                op_b = MUL_B_W'(tap_coef);
            end
            SEL_MEAN: begin
                op_a = filt;
                op_b = $signed(MUL_B_W'(mean_wt));
            end
            SEL_WET: begin
                op_a = mean_reg;
                op_b = $signed(MUL_B_W'(wet_gain));
            end
            default: begin
                op_a = MUL_A_W'(dry_sample);
                op_b = $signed(MUL_B_W'(dry_gain));
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
            sel_reg  <= ctrl.sel;
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (pv_reg && sel_reg == SEL_TAP) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        // scaling products are Q.16: drop 16 bits (floor)
        if (pv_reg && sel_reg == SEL_MEAN) begin
            mean_reg <= prod_reg[FILT_W+15:16];
        end
        if (pv_reg && sel_reg == SEL_WET) begin
            wet_reg <= prod_reg[FILT_W+15:16];
        end
        if (pv_reg && sel_reg == SEL_DRY) begin
            dry_reg <= prod_reg[FILT_W+15:16];
        end
    end

    assign sum    = (FILT_W + 1)'(wet_reg) + (FILT_W + 1)'(dry_reg);
    assign result = sat_sample(sum);

endmodule

[design/stereo_spaced_tap_fir_boost_top.sv]
// ----------------------------------------------------------------------------
// stereo_spaced_tap_fir_boost_top
// Stereo spaced-tap FIR boost with wet/dry mix and 24-bit saturation.
// ----------------------------------------------------------------------------
// A sample transaction (func 0) runs from acceptance until the result is
// loaded into the output register; s_ready is low meanwhile. The tap loop
// (skipped when tap_count is 0) dominates: each channel has one multiplier
// and the history memories have one read port, so one neighbour sample of
// one tap is processed per cycle, followed by the drain states D1 and D2,
// a mean, a dry and a wet scaling step on the same multiplier, then a wait state.
// A coefficient transaction (func 1) is taken while idle; it gives no result.
// A finished result may wait in the output register while the next
// transaction is accepted. The history is not cleared after reset: a fill
// count marks never-written entries, which read as zero, so the block is
// ready right out of reset.
// ----------------------------------------------------------------------------
module stereo_spaced_tap_fir_boost_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ssfb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ssfb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic signed [ssfb_pkg::SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [ssfb_pkg::SAMPLE_BITS-1:0] s_right_in,
    input  logic [ssfb_pkg::TAP_AW-1:0]          s_coef_index,
    input  logic signed [ssfb_pkg::COEF_BITS-1:0] s_coef_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ssfb_pkg::SAMPLE_BITS-1:0] m_left_out,
    output logic signed [ssfb_pkg::SAMPLE_BITS-1:0] m_right_out
);
    import ssfb_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TAP  = 4'd1;
    localparam logic [3:0] ST_D1   = 4'd2;
    localparam logic [3:0] ST_D2   = 4'd3;
    localparam logic [3:0] ST_MEAN = 4'd4;
    localparam logic [3:0] ST_DRY  = 4'd5;
    localparam logic [3:0] ST_WET  = 4'd6;
    localparam logic [3:0] ST_WAIT = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    // configuration
    gain_t                 wet_gain_reg;
    logic [TAPC_BITS-1:0]  tap_count_reg;
    logic [SPC_BITS-1:0]   spacing_reg;
    gain_t                 wg_eff;
    gain_t                 dry_gain;
    logic [TAP_CW-1:0]     taps_eff;
    logic [SPC_BITS-1:0]   sp_eff;
    gain_t                 weight;

    // sequencer
    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic [TAP_CW-1:0]     t_reg;
    logic [1:0]            k_reg;
    logic [BASE_W-1:0]     base_reg;
    logic                  iss_reg;
    logic                  s_fire;
    logic                  last_k;
    logic                  last_t;
    logic                  out_load;

    // history and coefficients
    sample_t               lhist_mem [HISTORY_DEPTH];
    sample_t               rhist_mem [HISTORY_DEPTH];
    coef_t                 coef_mem  [MAX_TAPS];
    logic [MAX_TAPS-1:0]   cvalid_reg;
    logic [HIST_AW-1:0]    ptr_reg;
    logic [HIST_AW-1:0]    ptr_inc;
    logic [FILL_W-1:0]     fill_reg;
    logic                  d_neg;
    logic [BASE_W-1:0]     d_val;
    logic [HIST_AW-1:0]    d_mod;
    logic [HIST_AW-1:0]    raddr;
    sample_t               lrd_reg;
    sample_t               rrd_reg;
    coef_t                 crd_reg;
    logic                  hok_reg;
    logic                  cok_reg;
    coef_t                 tap_coef;
    sample_t               ltap;
    sample_t               rtap;
    sample_t               xl_reg;
    sample_t               xr_reg;

    ssfb_ctrl_t            ctrl;
    sample_t               lres;
    sample_t               rres;
    logic                  m_valid_reg;
    sample_t               lout_reg;
    sample_t               rout_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_gain_reg  <= '0;
            tap_count_reg <= TAPC_BITS'(1);
            spacing_reg   <= SPC_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WET_GAIN:  wet_gain_reg  <= cfg_data[WG_BITS-1:0];
                REG_TAP_COUNT: tap_count_reg <= cfg_data[TAPC_BITS-1:0];
                REG_SPACING:   spacing_reg   <= cfg_data[SPC_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign wg_eff   = (wet_gain_reg > GAIN_ONE) ? GAIN_ONE : wet_gain_reg;
    // min(1, 1.5 - wet) is 1 exactly when wet <= 0.5
    assign dry_gain = (wg_eff < GAIN_HALF) ? GAIN_ONE : DRY_BASE - wg_eff;
    assign taps_eff = (TAP_CW'(tap_count_reg) > TAP_CW'(MAX_TAPS)) ?
                      TAP_CW'(MAX_TAPS) : TAP_CW'(tap_count_reg);
    assign sp_eff   = (spacing_reg == '0) ? SPC_BITS'(1) :
                      (spacing_reg > SPC_BITS'(MAX_SPACING)) ? SPC_BITS'(MAX_SPACING) :
                      spacing_reg;
    assign weight   = mean_weight(sp_eff);

    // ---------------- sequencer ----------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign last_k   = ({1'b0, k_reg} == sp_eff - SPC_BITS'(1));
    assign last_t   = (t_reg == taps_eff - TAP_CW'(1));
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && !s_func) begin
                    state_next = (taps_eff == '0) ? ST_MEAN : ST_TAP;
                end
            end
            ST_TAP: begin
                if (last_k && last_t) begin
                    state_next = ST_D1;
                end
            end
            ST_D1:   state_next = ST_D2;
            ST_D2:   state_next = ST_MEAN;
            ST_MEAN: state_next = ST_DRY;
            ST_DRY:  state_next = ST_WET;
            ST_WET:  state_next = ST_WAIT;
            ST_WAIT: state_next = ST_FIN;
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iss_reg   <= 1'b0;
            t_reg     <= '0;
            k_reg     <= '0;
            base_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iss_reg   <= (state_reg == ST_TAP);
            if (s_fire) begin
                t_reg    <= '0;
                k_reg    <= '0;
                base_reg <= '0;
            end else if (state_reg == ST_TAP) begin
                if (last_k) begin
                    k_reg    <= '0;
                    t_reg    <= t_reg + TAP_CW'(1);
                    base_reg <= base_reg + BASE_W'(sp_eff);
                end else begin
                    k_reg <= k_reg + 2'd1;
                end
            end
        end
    end

    // ---------------- history and coefficient stores ----------------
    // delay of neighbour k of tap t is t*spacing - k
    assign d_neg   = (base_reg < BASE_W'(k_reg));
    assign d_val   = base_reg - BASE_W'(k_reg);
    assign d_mod   = d_val[HIST_AW-1:0];
    assign raddr   = ptr_reg - d_mod;
    assign ptr_inc = ptr_reg + HIST_AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            fill_reg   <= '0;
            cvalid_reg <= '0;
        end else if (s_fire) begin
            if (!s_func) begin
                ptr_reg <= ptr_inc;
                if (fill_reg != FILL_W'(HISTORY_DEPTH)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end else begin
                cvalid_reg[s_coef_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && !s_func) begin
            lhist_mem[ptr_inc] <= s_left_in;
            rhist_mem[ptr_inc] <= s_right_in;
            xl_reg             <= s_left_in;
            xr_reg             <= s_right_in;
        end
        lrd_reg <= lhist_mem[raddr];
        rrd_reg <= rhist_mem[raddr];
        hok_reg <= !d_neg && (FILL_W'(d_mod) < fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_func) begin
            coef_mem[s_coef_index] <= s_coef_value;
        end
        crd_reg <= coef_mem[t_reg[TAP_AW-1:0]];
        cok_reg <= cvalid_reg[t_reg[TAP_AW-1:0]];
    end

    // a skipped or never-written term contributes a zero product
    assign tap_coef = (hok_reg && cok_reg) ? crd_reg : '0;
    assign ltap     = hok_reg ? lrd_reg : '0;
    assign rtap     = hok_reg ? rrd_reg : '0;

    // ---------------- channel datapaths ----------------
    always_comb begin
        ctrl.acc_clr = s_fire && !s_func;
        ctrl.mul_en  = iss_reg || (state_reg == ST_MEAN) || (state_reg == ST_DRY) ||
                       (state_reg == ST_WET);
        case (state_reg)
            ST_MEAN: ctrl.sel = SEL_MEAN;
            ST_DRY:  ctrl.sel = SEL_DRY;
            ST_WET:  ctrl.sel = SEL_WET;
            default: ctrl.sel = SEL_TAP;
        endcase
    end

    ssfb_chan u_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .tap_sample (ltap),
        .tap_coef   (tap_coef),
        .dry_sample (xl_reg),
        .mean_wt    (weight),
        .wet_gain   (wg_eff),
        .dry_gain   (dry_gain),
        .result     (lres)
    );

    ssfb_chan u_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .tap_sample (rtap),
        .tap_coef   (tap_coef),
        .dry_sample (xr_reg),
        .mean_wt    (weight),
        .wet_gain   (wg_eff),
        .dry_gain   (dry_gain),
        .result     (rres)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            lout_reg <= lres;
            rout_reg <= rres;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = lout_reg;
    assign m_right_out = rout_reg;

    // ---------------- assertions ----------------
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill count out of range");

    a_ptr_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_func) |=> (ptr_reg == $past(ptr_reg) + HIST_AW'(1)))
        else $error("write pointer did not advance on sample transaction");

    a_tap_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP) |-> ((t_reg < taps_eff) && ({1'b0, k_reg} < sp_eff)))
        else $error("tap loop counters out of range");

    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result presented outside final step");

    a_iss_follows_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_reg |-> $past(state_reg == ST_TAP))
        else $error("tap multiply issued without a tap read");

endmodule
